/* src/fti_pkg.sv */
// shared constants and types for the focus temperature interpolator
// no dependencies
package fti_pkg;

  localparam int TABLE_DEPTH_DEF = 64;
  localparam logic [7:0] MAX_PAIRS_RESET = 8'd100;

  // low hit counter
  localparam int LHW = 12;
  localparam logic [LHW-1:0] LOW_HITS_MAX = {LHW{1'b1}};

  // interpolation datapath widths
  localparam int TEMP_W  = 16;
  localparam int POS_W   = 32;
  localparam int DEN_W   = TEMP_W + 1;
  localparam int PROD_W  = DEN_W + POS_W + 1;
  localparam int BOUND_W = TEMP_W + 2;

  // operation codes
  localparam logic [1:0] FUNC_CLEAR = 2'd0;
  localparam logic [1:0] FUNC_ADD   = 2'd1;
  localparam logic [1:0] FUNC_FIND  = 2'd2;

  // status codes
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_NO_DATA = 2'd1;
  localparam logic [1:0] STATUS_FULL    = 2'd2;

  // one table entry as stored in memory
  typedef struct packed {
    logic [7:0]              filter;
    logic signed [TEMP_W-1:0] temperature;
    logic signed [POS_W-1:0]  position;
  } tbl_entry_t;

  localparam int TBL_W = $bits(tbl_entry_t);

endpackage

/* src/fti_ram.sv */
// generic single write port ram with registered read
// no dependencies
module fti_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/fti_div.sv */
// iterative signed divider, one quotient bit per cycle, truncates toward zero
// depends on fti_pkg
module fti_div
  import fti_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [PROD_W-1:0] dividend,
  input  logic signed [DEN_W-1:0]  divisor,
  output logic                     done,
  output logic signed [PROD_W-1:0] quotient
);

  localparam int CNTW = $clog2(PROD_W + 1);

  logic [PROD_W-1:0] num;
  logic [DEN_W-1:0]  den;
  logic [DEN_W-1:0]  rem;
  logic [CNTW-1:0]   cnt;
  logic              neg;
  logic              running;
  logic [DEN_W:0]    trial;
  logic              fits;

  assign trial = {rem, num[PROD_W-1]};
  assign fits  = trial >= {1'b0, den};

  // magnitude restoring division
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        num     <= dividend[PROD_W-1] ? PROD_W'(-dividend) : PROD_W'(dividend);
        den     <= divisor[DEN_W-1] ? DEN_W'(-divisor) : DEN_W'(divisor);
        rem     <= '0;
        neg     <= dividend[PROD_W-1] ^ divisor[DEN_W-1];
        cnt     <= CNTW'(PROD_W);
        running <= 1'b1;
      end else if (running) begin
        rem <= fits ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
        num <= {num[PROD_W-2:0], fits};
        cnt <= cnt - 1'b1;
        if (cnt == CNTW'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // apply sign
  assign quotient = neg ? -$signed(num) : $signed(num);

endmodule

/* src/focus_temperature_interpolator.sv */
// Clear, an add to an empty table and a rejected add go straight to the result; an
// add reads and shifts each larger entry; a find scans the table, then per pass searches
// it, divides when the bound temperatures differ and inserts into the sorted results.
// One transaction at a time; the table memory read port and the 50 iteration serial
// divider set the rate. Next input accepted while a result waits.
// Reset empties the table and sets max_pairs to 100; memories are not cleared.
module focus_temperature_interpolator
  import fti_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [7:0]               cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               func,
  input  logic [7:0]               filter,
  input  logic signed [TEMP_W-1:0] temperature,
  input  logic signed [POS_W-1:0]  position,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [1:0]               status,
  output logic signed [POS_W-1:0]  position_res
);

  localparam int AW           = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW           = $clog2(TABLE_DEPTH + 1);
  localparam int RESULT_DEPTH = (TABLE_DEPTH + 1) / 2;
  localparam int RAW          = (RESULT_DEPTH > 1) ? $clog2(RESULT_DEPTH) : 1;
  localparam int RCW          = $clog2(RESULT_DEPTH + 1);
  localparam int CMPW         = CW + 9;
  localparam int SUM_W        = PROD_W + 1;

  typedef enum logic [27:0] {
    S_IDLE     = 28'd1 << 0,
    S_ADD_RD   = 28'd1 << 1,
    S_ADD_CMP  = 28'd1 << 2,
    S_ADD_PUT  = 28'd1 << 3,
    S_SCAN_RD  = 28'd1 << 4,
    S_SCAN_USE = 28'd1 << 5,
    S_SETUP    = 28'd1 << 6,
    S_PASS     = 28'd1 << 7,
    S_P_RD     = 28'd1 << 8,
    S_P_USE    = 28'd1 << 9,
    S_BRK      = 28'd1 << 10,
    S_LO_RD    = 28'd1 << 11,
    S_LO_USE   = 28'd1 << 12,
    S_HI_RD    = 28'd1 << 13,
    S_HI_USE   = 28'd1 << 14,
    S_MUL      = 28'd1 << 15,
    S_DSTART   = 28'd1 << 16,
    S_DIV      = 28'd1 << 17,
    S_SUM      = 28'd1 << 18,
    S_INS      = 28'd1 << 19,
    S_R_RD     = 28'd1 << 20,
    S_R_USE    = 28'd1 << 21,
    S_R_PUT    = 28'd1 << 22,
    S_NEXT     = 28'd1 << 23,
    S_MED      = 28'd1 << 24,
    S_M_RD     = 28'd1 << 25,
    S_M_USE    = 28'd1 << 26,
    S_DONE     = 28'd1 << 27
  } state_t;

  state_t state;

  logic [7:0]               max_pairs;
  logic [CW-1:0]            count;
  logic [7:0]               q_filter;
  logic signed [TEMP_W-1:0] q_temp;
  logic signed [POS_W-1:0]  q_pos;
  logic [AW-1:0]            tidx;
  logic [AW-1:0]            first;
  logic [AW-1:0]            last;
  logic                     any_hit;
  logic [AW-1:0]            lo;
  logic [AW-1:0]            hi;
  logic [LHW-1:0]           low_hits;
  logic                     high_hit;
  logic [7:0]               passes;
  logic [RCW-1:0]           rcnt;
  logic [RAW-1:0]           ridx;
  logic signed [BOUND_W-1:0] lt;
  logic signed [BOUND_W-1:0] ht;
  logic signed [TEMP_W-1:0] tl;
  logic signed [TEMP_W-1:0] th;
  logic signed [POS_W-1:0]  pl;
  logic signed [POS_W-1:0]  ph;
  logic signed [PROD_W-1:0] prod;
  logic signed [POS_W-1:0]  val;
  logic [1:0]               res_status;
  logic signed [POS_W-1:0]  res_pos;

  // memory ports
  logic             tbl_we;
  logic [AW-1:0]    tbl_waddr;
  tbl_entry_t       tbl_wdata;
  tbl_entry_t       tbl_rdata;
  logic             res_we;
  logic [RAW-1:0]   res_waddr;
  logic [POS_W-1:0] res_wdata;
  logic [POS_W-1:0] res_rdata;

  // divider
  logic                     div_start;
  logic                     div_done;
  logic signed [PROD_W-1:0] quo;
  logic signed [DEN_W-1:0]  den;

  tbl_entry_t new_entry;
  logic       in_fire;
  logic       last_idx;
  logic       match;
  logic       le_hit;
  logic       ge_hit;
  logic [AW-1:0] lo_final;
  logic [LHW:0]  lo_diff;
  logic [CMPW-1:0] half;
  logic signed [SUM_W-1:0] sum;
  logic       sum_ovf;
  logic signed [DEN_W-1:0]  dt;
  logic signed [POS_W:0]    dp;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;

  assign new_entry = '{filter: q_filter, temperature: q_temp, position: q_pos};

  // table scan helpers
  assign last_idx = (tidx == AW'(count - 1'b1));
  assign match    = (tbl_rdata.filter == q_filter);
  assign le_hit   = $signed({{2{tbl_rdata.temperature[TEMP_W-1]}}, tbl_rdata.temperature}) <= lt;
  assign ge_hit   = $signed({{2{tbl_rdata.temperature[TEMP_W-1]}}, tbl_rdata.temperature}) >= ht;

  // extrapolation fallback index: count-1-low_hits clamped at zero
  assign lo_diff  = (LHW+1)'(count - 1'b1) - {1'b0, low_hits};
  assign lo_final = high_hit ? lo : (lo_diff[LHW] ? '0 : AW'(lo_diff));

  // pass count before the max_pairs cap
  assign half = (CMPW'(count) + CMPW'(1)) >> 1;

  // interpolation arithmetic
  assign dt  = $signed({q_temp[TEMP_W-1], q_temp}) - $signed({tl[TEMP_W-1], tl});
  assign dp  = $signed({ph[POS_W-1], ph}) - $signed({pl[POS_W-1], pl});
  assign den = $signed({th[TEMP_W-1], th}) - $signed({tl[TEMP_W-1], tl});
  assign sum = $signed({{(SUM_W-POS_W){pl[POS_W-1]}}, pl}) + $signed({quo[PROD_W-1], quo});
  assign sum_ovf = !((&sum[SUM_W-1:POS_W-1]) || !(|sum[SUM_W-1:POS_W-1]));

  assign div_start = (state == S_DSTART);

  // memory write control
  always_comb begin
    tbl_we    = 1'b0;
    tbl_waddr = tidx + 1'b1;
    tbl_wdata = new_entry;
    res_we    = 1'b0;
    res_waddr = ridx + 1'b1;
    res_wdata = val;
    unique case (state)
      S_IDLE: begin
        if (in_fire && func == FUNC_ADD && count == '0) begin
          tbl_we    = 1'b1;
          tbl_waddr = '0;
          tbl_wdata = '{filter: filter, temperature: temperature, position: position};
        end
      end
      S_ADD_CMP: begin
        tbl_we = 1'b1;
        if (tbl_rdata.temperature > q_temp) begin
          tbl_wdata = tbl_rdata;
        end
      end
      S_ADD_PUT: begin
        tbl_we    = 1'b1;
        tbl_waddr = '0;
      end
      S_INS: begin
        if (rcnt == '0) begin
          res_we    = 1'b1;
          res_waddr = '0;
        end
      end
      S_R_USE: begin
        res_we = 1'b1;
        if ($signed(res_rdata) > val) begin
          res_wdata = res_rdata;
        end
      end
      S_R_PUT: begin
        res_we    = 1'b1;
        res_waddr = '0;
      end
      default: begin
      end
    endcase
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_pairs <= MAX_PAIRS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_pairs <= cfg_data;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      low_hits  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            q_filter   <= filter;
            q_temp     <= temperature;
            q_pos      <= position;
            res_status <= STATUS_OK;
            res_pos    <= '0;
            state      <= S_DONE;
            case (func)
              FUNC_CLEAR: count <= '0;
              FUNC_ADD: begin
                if (count >= CW'(TABLE_DEPTH)) begin
                  res_status <= STATUS_FULL;
                end else if (count == '0) begin
                  count <= count + 1'b1;
                end else begin
                  tidx  <= AW'(count - 1'b1);
                  state <= S_ADD_RD;
                end
              end
              FUNC_FIND: begin
                low_hits <= '0;
                any_hit  <= 1'b0;
                tidx     <= '0;
                if (count == '0) begin
                  res_status <= STATUS_NO_DATA;
                end else begin
                  state <= S_SCAN_RD;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_ADD_RD: state <= S_ADD_CMP;
        S_ADD_CMP: begin
          if (tbl_rdata.temperature > q_temp) begin
            if (tidx == '0) begin
              state <= S_ADD_PUT;
            end else begin
              tidx  <= tidx - 1'b1;
              state <= S_ADD_RD;
            end
          end else begin
            count <= count + 1'b1;
            state <= S_DONE;
          end
        end
        S_ADD_PUT: begin
          count <= count + 1'b1;
          state <= S_DONE;
        end
        S_SCAN_RD: state <= S_SCAN_USE;
        S_SCAN_USE: begin
          if (match) begin
            if (!any_hit) begin
              first <= tidx;
            end
            last    <= tidx;
            any_hit <= 1'b1;
          end
          if (last_idx) begin
            state <= S_SETUP;
          end else begin
            tidx  <= tidx + 1'b1;
            state <= S_SCAN_RD;
          end
        end
        S_SETUP: begin
          if (!any_hit) begin
            res_status <= STATUS_NO_DATA;
            state      <= S_DONE;
          end else begin
            passes   <= (half < CMPW'(max_pairs)) ? 8'(half) : max_pairs;
            high_hit <= 1'b0;
            lt       <= BOUND_W'(q_temp);
            ht       <= BOUND_W'(q_temp);
            rcnt     <= '0;
            state    <= S_PASS;
          end
        end
        S_PASS: begin
          if (passes == '0 || rcnt == RCW'(RESULT_DEPTH)) begin
            state <= S_MED;
          end else begin
            lo    <= first;
            hi    <= last;
            tidx  <= '0;
            state <= S_P_RD;
          end
        end
        S_P_RD: state <= S_P_USE;
        S_P_USE: begin
          if (match && le_hit) begin
            lo <= tidx;
            if (low_hits != LOW_HITS_MAX) begin
              low_hits <= low_hits + 1'b1;
            end
          end
          if (match && ge_hit) begin
            hi       <= tidx;
            high_hit <= 1'b1;
            state    <= S_BRK;
          end else if (last_idx) begin
            state <= S_BRK;
          end else begin
            tidx  <= tidx + 1'b1;
            state <= S_P_RD;
          end
        end
        S_BRK: begin
          if (!high_hit) begin
            hi <= last;
          end
          tidx  <= lo_final;
          state <= S_LO_RD;
        end
        S_LO_RD: state <= S_LO_USE;
        S_LO_USE: begin
          tl    <= tbl_rdata.temperature;
          pl    <= tbl_rdata.position;
          tidx  <= hi;
          state <= S_HI_RD;
        end
        S_HI_RD: state <= S_HI_USE;
        S_HI_USE: begin
          th    <= tbl_rdata.temperature;
          ph    <= tbl_rdata.position;
          state <= S_MUL;
        end
        S_MUL: begin
          prod <= $signed({{(PROD_W-DEN_W){dt[DEN_W-1]}}, dt}) *
                  $signed({{(PROD_W-POS_W-1){dp[POS_W]}}, dp});
          lt   <= $signed({{2{tl[TEMP_W-1]}}, tl}) - BOUND_W'(1);
          ht   <= $signed({{2{th[TEMP_W-1]}}, th}) + BOUND_W'(1);
          if (th == tl) begin
            val   <= pl;
            state <= S_INS;
          end else begin
            state <= S_DSTART;
          end
        end
        S_DSTART: state <= S_DIV;
        S_DIV: begin
          if (div_done) begin
            state <= S_SUM;
          end
        end
        S_SUM: begin
          if (sum_ovf) begin
            val <= sum[SUM_W-1] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
          end else begin
            val <= POS_W'(sum);
          end
          state <= S_INS;
        end
        S_INS: begin
          if (rcnt == '0) begin
            state <= S_NEXT;
          end else begin
            ridx  <= RAW'(rcnt - 1'b1);
            state <= S_R_RD;
          end
        end
        S_R_RD: state <= S_R_USE;
        S_R_USE: begin
          if ($signed(res_rdata) > val) begin
            if (ridx == '0) begin
              state <= S_R_PUT;
            end else begin
              ridx  <= ridx - 1'b1;
              state <= S_R_RD;
            end
          end else begin
            state <= S_NEXT;
          end
        end
        S_R_PUT: state <= S_NEXT;
        S_NEXT: begin
          rcnt   <= rcnt + 1'b1;
          passes <= passes - 1'b1;
          state  <= S_PASS;
        end
        S_MED: begin
          if (rcnt == '0) begin
            res_status <= STATUS_NO_DATA;
            state      <= S_DONE;
          end else begin
            ridx  <= RAW'(rcnt >> 1);
            state <= S_M_RD;
          end
        end
        S_M_RD: state <= S_M_USE;
        S_M_USE: begin
          res_pos <= res_rdata;
          state   <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            status       <= res_status;
            position_res <= res_pos;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // entry table
  fti_ram #(
    .WIDTH(TBL_W),
    .DEPTH(TABLE_DEPTH),
    .AW   (AW)
  ) u_tbl (
    .clk  (clk),
    .we   (tbl_we),
    .waddr(tbl_waddr),
    .wdata(tbl_wdata),
    .raddr(tidx),
    .rdata(tbl_rdata)
  );

  // sorted interpolation results
  fti_ram #(
    .WIDTH(POS_W),
    .DEPTH(RESULT_DEPTH),
    .AW   (RAW)
  ) u_res (
    .clk  (clk),
    .we   (res_we),
    .waddr(res_waddr),
    .wdata(res_wdata),
    .raddr(ridx),
    .rdata(res_rdata)
  );

  fti_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(prod),
    .divisor (den),
    .done    (div_done),
    .quotient(quo)
  );

endmodule

/* tb/tb_focus_temperature_interpolator.sv */
// testbench for the focus temperature interpolator: directed and random transactions
// checked against a behavioral predictor; depends on fti_pkg and the block's RTL
`timescale 1ns / 1ps

module tb_focus_temperature_interpolator
  import fti_pkg::*;
;

  localparam int DEPTH = 64;
  localparam int SORT_DEPTH = (DEPTH + 1) / 2;
  localparam logic [1:0] FUNC_SPARE = 2'd3;
  localparam int HITS_CAP = 4095;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [7:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] func = '0;
  logic [7:0] filter = '0;
  logic signed [15:0] temperature = '0;
  logic signed [31:0] position = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] status;
  logic signed [31:0] position_res;

  focus_temperature_interpolator DUT (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .func(func), .filter(filter), .temperature(temperature), .position(position),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .position_res(position_res)
  );

  always #4 clk = ~clk;

  // predictor state
  logic [7:0] tbl_filter [DEPTH];
  int tbl_temp [DEPTH];
  int tbl_pos [DEPTH];
  int tbl_count = 0;
  int max_pairs = 100;
  int med_list [SORT_DEPTH];

  // expected responses, oldest first
  logic [1:0] exp_status_q [$];
  logic signed [31:0] exp_pos_q [$];

  int errors = 0;
  int items_sent = 0;
  bit quiet = 1'b0;
  int stall_left = 0;

  // filters and temperature window used by the random phases
  logic [7:0] filt_pool [3];
  bit wide_temps;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 19);
    if (quiet || r < 10) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int interp(int t, int lo, int hi);
    longint tl, th, pl, ph, v;
    tl = tbl_temp[lo];
    th = tbl_temp[hi];
    pl = tbl_pos[lo];
    ph = tbl_pos[hi];
    v = pl;
    if (th != tl) v = pl + ((longint'(t) - tl) * (ph - pl)) / (th - tl);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return int'(v);
  endfunction

  // median of the outward interpolation passes; returns 0 when no data
  function automatic bit find_median(logic [7:0] f, int t, output int med);
    int n, passes, cnt, first, last, lo, hi, e, v, lt, ht, hits;
    bit any, high_hit;
    n = tbl_count;
    cnt = 0; first = 0; last = 0; any = 0; high_hit = 0; hits = 0;
    lt = t; ht = t; med = 0;
    if (n == 0) return 0;
    for (int i = 0; i < n; i++)
      if (tbl_filter[i] == f) begin
        if (!any) first = i;
        last = i;
        any = 1;
      end
    if (!any) return 0;
    passes = (n + 1) / 2;
    if (passes > max_pairs) passes = max_pairs;
    while (passes > 0 && cnt < SORT_DEPTH) begin
      passes--;
      lo = first;
      hi = last;
      for (int i = 0; i < n; i++) begin
        if (tbl_filter[i] != f) continue;
        if (tbl_temp[i] <= lt) begin
          lo = i;
          if (hits < HITS_CAP) hits++;
        end
        if (tbl_temp[i] >= ht) begin
          hi = i;
          high_hit = 1;
          break;
        end
      end
      // extrapolation fallback, low index taken from the cumulative hit count
      if (!high_hit) begin
        hi = last;
        lo = (n - 1 >= hits) ? n - 1 - hits : 0;
      end
      v = interp(t, lo, hi);
      e = 0;
      while (e < cnt && med_list[e] <= v) e++;
      for (int i = cnt; i > e; i--) med_list[i] = med_list[i - 1];
      med_list[e] = v;
      cnt++;
      lt = tbl_temp[lo] - 1;
      ht = tbl_temp[hi] + 1;
    end
    if (cnt == 0) return 0;
    med = med_list[cnt / 2];
    return 1;
  endfunction

  // update table state and queue the expected response of one transaction
  function automatic void predict_response(logic [1:0] fn, logic [7:0] f, int t, int p);
    logic [1:0] st;
    int res, at;
    st = STATUS_OK;
    res = 0;
    case (fn)
      FUNC_CLEAR: tbl_count = 0;
      FUNC_ADD: begin
        if (tbl_count >= DEPTH) st = STATUS_FULL;
        else begin
          at = 0;
          while (at < tbl_count && tbl_temp[at] <= t) at++;
          for (int i = tbl_count; i > at; i--) begin
            tbl_filter[i] = tbl_filter[i - 1];
            tbl_temp[i] = tbl_temp[i - 1];
            tbl_pos[i] = tbl_pos[i - 1];
          end
          tbl_filter[at] = f;
          tbl_temp[at] = t;
          tbl_pos[at] = p;
          tbl_count++;
        end
      end
      FUNC_FIND: begin
        if (!find_median(f, t, res)) begin
          st = STATUS_NO_DATA;
          res = 0;
        end
      end
      default: ;
    endcase
    exp_status_q.push_back(st);
    exp_pos_q.push_back(res);
  endfunction

  // send one transaction; valid stays high until the next call or drain
  task automatic send_item(logic [1:0] fn, logic [7:0] f, logic signed [15:0] t,
                           logic signed [31:0] p);
    int g;
    g = gap_len();
    @(negedge clk);
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_valid <= 1'b1;
    func <= fn;
    filter <= f;
    temperature <= t;
    position <= p;
    do @(posedge clk); while (!in_ready);
    predict_response(fn, f, int'(t), int'(p));
    items_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (exp_status_q.size() == 0);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_max_pairs(logic [7:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    max_pairs = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // receiver stalls
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if (!quiet) stall_left <= gap_len();
    end
  end

  // response checker
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (exp_status_q.size() == 0) begin
        $display("%0t: unexpected response status=%0d position_res=%0d",
                 $time, status, position_res);
        errors++;
      end else begin
        if (status !== exp_status_q[0]) begin
          $display("%0t: status mismatch expected %0d actual %0d",
                   $time, exp_status_q[0], status);
          errors++;
        end
        if (position_res !== exp_pos_q[0]) begin
          $display("%0t: position_res mismatch expected %0d actual %0d",
                   $time, exp_pos_q[0], position_res);
          errors++;
        end
        void'(exp_status_q.pop_front());
        void'(exp_pos_q.pop_front());
      end
    end
  end

  // operations, extremes, saturation and extrapolation
  task automatic test_basic_ops();
    send_item(FUNC_FIND, 8'h41, 16'sd0, 32'sd0);
    send_item(FUNC_SPARE, 8'hFF, -16'sd1, -32'sd1);
    send_item(FUNC_ADD, 8'h41, 16'sd100, 32'sd1000);
    send_item(FUNC_ADD, 8'h41, 16'sd300, 32'sd5000);
    send_item(FUNC_ADD, 8'h42, 16'sd200, 32'sd777);
    send_item(FUNC_ADD, 8'h41, 16'sd300, 32'sd6000);
    send_item(FUNC_ADD, 8'h41, -16'sd32768, 32'h8000_0000);
    send_item(FUNC_ADD, 8'h41, 16'sd32767, 32'h7FFF_FFFF);
    send_item(FUNC_FIND, 8'h41, 16'sd200, 32'sd0);
    send_item(FUNC_FIND, 8'h41, 16'sd300, 32'sd0);
    send_item(FUNC_FIND, 8'h42, 16'sd200, 32'sd0);
    send_item(FUNC_FIND, 8'h42, -16'sd32768, 32'sd0);
    send_item(FUNC_FIND, 8'h43, 16'sd200, 32'sd0);
    send_item(FUNC_CLEAR, 8'h00, 16'sd0, 32'sd0);
    // steep slope extrapolated far out saturates
    send_item(FUNC_ADD, 8'hFF, 16'sd0, 32'sd0);
    send_item(FUNC_ADD, 8'hFF, 16'sd1, 32'h7FFF_0000);
    send_item(FUNC_FIND, 8'hFF, 16'sd32767, 32'sd0);
    send_item(FUNC_FIND, 8'hFF, -16'sd32768, 32'sd0);
    send_item(FUNC_CLEAR, 8'h00, 16'sd0, 32'sd0);
    send_item(FUNC_FIND, 8'hFF, 16'sd0, 32'sd0);
  endtask

  // full table, add rejected, long finds
  task automatic test_table_full();
    send_item(FUNC_CLEAR, 8'h00, 16'sd0, 32'sd0);
    for (int i = 0; i < DEPTH; i++)
      send_item(FUNC_ADD, (i % 3 == 0) ? 8'h10 : 8'h20,
                16'(($urandom_range(0, 40) - 20) * 10), $urandom_range(0, 200000) - 100000);
    send_item(FUNC_ADD, 8'h10, 16'sd5, 32'sd5);
    send_item(FUNC_FIND, 8'h10, 16'sd0, 32'sd0);
    send_item(FUNC_FIND, 8'h20, -16'sd1000, 32'sd0);
  endtask

  // pass limit at its extremes
  task automatic test_max_pairs();
    write_max_pairs(8'd0);
    send_item(FUNC_FIND, 8'h10, 16'sd0, 32'sd0);
    write_max_pairs(8'd1);
    send_item(FUNC_FIND, 8'h10, 16'sd50, 32'sd0);
    write_max_pairs(8'd255);
    send_item(FUNC_FIND, 8'h20, 16'sd50, 32'sd0);
    write_max_pairs(8'd3);
    send_item(FUNC_FIND, 8'h20, 16'sd50, 32'sd0);
  endtask

  function automatic logic [7:0] pick_filter();
    if ($urandom_range(0, 9) == 0) return 8'($urandom);
    return filt_pool[$urandom_range(0, 2)];
  endfunction

  function automatic logic signed [15:0] pick_temp();
    if (wide_temps || $urandom_range(0, 9) == 0) return 16'($urandom);
    return 16'(($urandom_range(0, 60) - 30) * 10 + $urandom_range(0, 2));
  endfunction

  // random build-then-query phases
  task automatic test_random_phases();
    int k, nfind, r;
    logic signed [31:0] p;
    while (items_sent < 290) begin
      quiet = ($urandom_range(0, 4) == 0);
      r = $urandom_range(0, 5);
      if (r == 0) write_max_pairs(8'($urandom));
      else if (r == 1) write_max_pairs(8'($urandom_range(1, 4)));
      else if (r == 2) write_max_pairs(8'd100);
      for (int i = 0; i < 3; i++) filt_pool[i] = 8'($urandom);
      wide_temps = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 4) != 0) send_item(FUNC_CLEAR, 8'($urandom), 16'($urandom), $urandom);
      k = ($urandom_range(0, 9) == 0) ? 66 : $urandom_range(1, 10);
      for (int i = 0; i < k; i++) begin
        p = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 40000) - 20000;
        send_item(FUNC_ADD, pick_filter(), pick_temp(), p);
      end
      nfind = (k > 60) ? 3 : $urandom_range(2, 6);
      for (int i = 0; i < nfind; i++)
        send_item(FUNC_FIND, pick_filter(), pick_temp(), $urandom);
      if ($urandom_range(0, 5) == 0) send_item(FUNC_SPARE, 8'($urandom), 16'($urandom), $urandom);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_basic_ops();
    test_table_full();
    test_max_pairs();
    write_max_pairs(8'd100);
    test_random_phases();
    drain();
    repeat (100) @(posedge clk);
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #80_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

/* sim.f */
src/fti_pkg.sv
src/fti_ram.sv
src/fti_div.sv
src/focus_temperature_interpolator.sv
tb/tb_focus_temperature_interpolator.sv
